// ===== rtl/aes128_block_cipher_defines.svh =====
// Assertion macros used by the port-level checker of the AES-128 block.
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/aes_pkg.sv =====
// Types, constants and byte-level functions of the AES-128 block.
package aes_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int ROUND_W    = 4;

   typedef logic [ROUND_W-1:0] round_idx_type;

   typedef struct packed {
      logic        cmd;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } aes_req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } aes_rsp_type;

   typedef struct packed {
      logic          start;
      round_idx_type rd_addr;
   } key_ctl_type;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
   localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY    = 8'h1b;

   localparam round_idx_type LAST_ROUND = round_idx_type'(NUM_ROUNDS);

   localparam logic [2047:0] FWD_SBOX = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   localparam logic [2047:0] INV_SBOX = {
      128'h52096ad53036a538bf40a39e81f3d7fb,
      128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e,
      128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692,
      128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506,
      128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673,
      128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b,
      128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f,
      128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961,
      128'h172b047eba77d626e169146355210c7d
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return FWD_SBOX[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
      logic [7:0]  a [4];
      logic [7:0]  m2, m4, m8;
      logic [7:0]  x1 [4];
      logic [7:0]  x2 [4];
      logic [7:0]  x3 [4];
      logic [7:0]  x9 [4];
      logic [7:0]  xb [4];
      logic [7:0]  xd [4];
      logic [7:0]  xe [4];
      logic [31:0] o;
      for (int r = 0; r < 4; r++) begin
         a[r]  = w[31-8*r -: 8];
         m2    = xtime(a[r]);
         m4    = xtime(m2);
         m8    = xtime(m4);
         x1[r] = a[r];
         x2[r] = m2;
         x3[r] = m2 ^ a[r];
         x9[r] = m8 ^ a[r];
         xb[r] = m8 ^ m2 ^ a[r];
         xd[r] = m8 ^ m4 ^ a[r];
         xe[r] = m8 ^ m4 ^ m2;
      end
      for (int r = 0; r < 4; r++) begin
         if (inv) begin
            o[31-8*r -: 8] = xe[r] ^ xb[(r+1)%4] ^ xd[(r+2)%4] ^ x9[(r+3)%4];
         end else begin
            o[31-8*r -: 8] = x2[r] ^ x3[(r+1)%4] ^ x1[(r+2)%4] ^ x1[(r+3)%4];
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      int           src;
      for (int k = 0; k < 16; k++) begin
         if (inv) begin
            src = (((k/4) + 4 - (k%4)) % 4) * 4 + (k%4);
            t[127-8*k -: 8] = inv_sbox(s[127-8*src -: 8]);
         end else begin
            src = (((k/4) + (k%4)) % 4) * 4 + (k%4);
            t[127-8*k -: 8] = sbox(s[127-8*src -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
      end
      return t;
   endfunction

endpackage

// ===== rtl/aes128_block_cipher.sv =====
// AES-128 encrypt/decrypt of one 16-byte block per item, one round per cycle.
// An accepted item runs a key fetch state, the initial key addition and ten
// rounds in the shared round unit, and then loads the result register, which
// waits while a previous result is still stalled; no new item is taken before
// that load, and the next item can be accepted in the cycle after it. The first
// item after reset or after a key write first expands the key schedule, one
// round key per cycle. The result register lets a new item start while the
// previous result still waits.
module aes128_block_cipher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aes_pkg::aes_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aes_pkg::aes_rsp_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [63:0]          csr_pwdata,
   output logic [63:0]          csr_prdata,
   output logic                 csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_FETCH,
      ST_RUN,
      ST_OUT
   } state_type;

   state_type              state_ff;
   logic [63:0]            key_high_ff, key_low_ff;
   logic                   sched_ready_ff;
   logic                   dec_ff;
   logic [127:0]           blk_ff, blk_in;
   aes_pkg::round_idx_type cnt_ff;
   logic                   rsp_valid_ff;
   aes_pkg::aes_rsp_type   rsp_data_ff;
   aes_pkg::key_ctl_type   key_ctl;
   logic                   key_busy;
   logic [127:0]           cur_rkey;
   logic [127:0]           round_out;
   logic                   csr_write;
   logic                   req_take;
   logic                   out_free;
   aes_pkg::round_idx_type fetch_idx;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (csr_paddr)
         aes_pkg::ADDR_KEY_HIGH: csr_prdata = key_high_ff;
         aes_pkg::ADDR_KEY_LOW:  csr_prdata = key_low_ff;
         default:                csr_prdata = '0;
      endcase
   end

   always_comb begin
      priority if (state_ff == ST_FETCH) begin
         fetch_idx = '0;
      end else if (cnt_ff == aes_pkg::LAST_ROUND) begin
         fetch_idx = '0;
      end else begin
         fetch_idx = cnt_ff + 1'b1;
      end
      key_ctl.start   = req_take && !sched_ready_ff;
      key_ctl.rd_addr = dec_ff ? aes_pkg::LAST_ROUND - fetch_idx : fetch_idx;
      blk_in          = (cnt_ff == '0) ? (blk_ff ^ cur_rkey) : round_out;
   end

   aes_key_sched u_key_sched (
      .clock   (clock),
      .reset   (reset),
      .key     ({key_high_ff, key_low_ff}),
      .ctl     (key_ctl),
      .busy    (key_busy),
      .rd_data (cur_rkey)
   );

   aes_round u_round (
      .state      (blk_ff),
      .rkey       (cur_rkey),
      .dec        (dec_ff),
      .last       (cnt_ff == aes_pkg::LAST_ROUND),
      .next_state (round_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write) begin
         if (csr_paddr == aes_pkg::ADDR_KEY_HIGH) begin
            key_high_ff <= csr_pwdata;
         end
         if (csr_paddr == aes_pkg::ADDR_KEY_LOW) begin
            key_low_ff <= csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sched_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         if (csr_write && (csr_paddr == aes_pkg::ADDR_KEY_HIGH ||
                           csr_paddr == aes_pkg::ADDR_KEY_LOW)) begin
            sched_ready_ff <= 1'b0;
         end else if (key_ctl.start) begin
            sched_ready_ff <= 1'b1;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  dec_ff   <= (req_data.cmd == aes_pkg::CMD_DECRYPT);
                  blk_ff   <= {req_data.block_high, req_data.block_low};
                  state_ff <= sched_ready_ff ? ST_FETCH : ST_EXPAND;
               end
            end
            ST_EXPAND: begin
               if (!key_busy) begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               cnt_ff   <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               blk_ff <= blk_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == aes_pkg::LAST_ROUND) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_data_ff <= {blk_ff[127:64], blk_ff[63:0]};
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/aes_round.sv =====
// One AES round, forward or inverse, shared by all rounds of an item.
module aes_round (
   input  logic [127:0] state,
   input  logic [127:0] rkey,
   input  logic         dec,
   input  logic         last,
   output logic [127:0] next_state
);

   logic [127:0] sub_out;
   logic [127:0] keyed;

   always_comb begin
      sub_out = aes_pkg::sub_shift(state, dec);
      if (dec) begin
         keyed      = sub_out ^ rkey;
         next_state = last ? keyed : aes_pkg::mix_all(keyed, 1'b1);
      end else begin
         keyed      = last ? sub_out : aes_pkg::mix_all(sub_out, 1'b0);
         next_state = keyed ^ rkey;
      end
   end

endmodule

// ===== rtl/aes_key_sched.sv =====
// Key expansion, one round key per cycle, into an eleven-row round key memory.
module aes_key_sched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [127:0]          key,
   input  aes_pkg::key_ctl_type  ctl,
   output logic                  busy,
   output logic [127:0]          rd_data
);

   logic [127:0]           mem [aes_pkg::NUM_ROUNDS+1];
   logic                   busy_ff;
   aes_pkg::round_idx_type row_ff, row_in;
   logic [7:0]             rcon_ff, rcon_in;
   logic [127:0]           prev_ff, prev_in;
   logic [127:0]           wdata;
   logic [127:0]           rd_data_ff;
   logic [31:0]            t, n0, n1, n2, n3;

   always_comb begin
      t  = aes_pkg::sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rcon_ff, 24'h000000};
      n0 = prev_ff[127:96] ^ t;
      n1 = prev_ff[95:64] ^ n0;
      n2 = prev_ff[63:32] ^ n1;
      n3 = prev_ff[31:0] ^ n2;
      wdata   = (row_ff == '0) ? prev_ff : {n0, n1, n2, n3};
      prev_in = ctl.start ? key : wdata;
      rcon_in = ctl.start ? aes_pkg::RCON_FIRST :
                ((row_ff == '0) ? rcon_ff : aes_pkg::xtime(rcon_ff));
      row_in  = ctl.start ? '0 : row_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && row_ff == aes_pkg::LAST_ROUND) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start || busy_ff) begin
         row_ff  <= row_in;
         rcon_ff <= rcon_in;
         prev_ff <= prev_in;
      end
      if (busy_ff && !ctl.start) begin
         mem[row_ff] <= wdata;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign busy    = busy_ff;
   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/aes_checker.sv =====
// Port-level checks of the AES-128 block and their binding to the top level.
`include "aes128_block_cipher_defines.svh"

module aes_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input aes_pkg::aes_rsp_type rsp_data
);

   `AES_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `AES_ASSERT_NEXT(a_no_early_result, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))
   `AES_ASSERT_NOW(a_idle_after_reset, clock, reset, $fell(reset), !rsp_valid)
   `AES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_data))

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench of the AES-128 block cipher with its own cipher predictor.
`timescale 1ns / 1ps
module tb_top;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   aes_pkg::aes_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   aes_pkg::aes_rsp_type rsp_data;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [3:0]           csr_paddr;
   logic [63:0]          csr_pwdata;
   logic [63:0]          csr_prdata;
   logic                 csr_pready;

   aes128_block_cipher DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   typedef struct {
      logic [7:0] byte_val [16];
   } cipher_state_type;

   typedef struct {
      logic        cmd;
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        known;
      logic [63:0] want_high;
      logic [63:0] want_low;
   } vector_type;

   logic [7:0]           fwd_table [256];
   logic [7:0]           inv_table [256];
   logic [63:0]          cur_key_high;
   logic [63:0]          cur_key_low;
   logic [31:0]          sched_words [44];
   aes_pkg::aes_rsp_type pending_results [$];
   int                   error_count;
   int                   quiet_cycles;
   int                   sender_idle_pct;
   int                   receiver_idle_pct;
   int                   hold_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] gf_times2(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) acc ^= a;
         a = gf_times2(a);
      end
      return acc;
   endfunction

   task automatic build_tables();
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] x;
      p = 8'h01;
      q = 8'h01;
      fwd_table[0] = 8'h63;
      do begin
         p = p ^ gf_times2(p);
         q = q ^ (q << 1);
         q = q ^ (q << 2);
         q = q ^ (q << 4);
         if (q[7]) q ^= 8'h09;
         x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
             ^ {q[3:0], q[7:4]} ^ 8'h63;
         fwd_table[p] = x;
      end while (p != 8'h01);
      for (int k = 0; k < 256; k++) inv_table[fwd_table[k]] = k[7:0];
   endtask

   task automatic expand_key_schedule();
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      sched_words[0] = cur_key_high[63:32];
      sched_words[1] = cur_key_high[31:0];
      sched_words[2] = cur_key_low[63:32];
      sched_words[3] = cur_key_low[31:0];
      for (int k = 4; k < 44; k++) begin
         t = sched_words[k-1];
         if (k % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_table[t[31:24]], fwd_table[t[23:16]], fwd_table[t[15:8]],
                 fwd_table[t[7:0]]} ^ {rcon, 24'h0};
            rcon = gf_times2(rcon);
         end
         sched_words[k] = sched_words[k-4] ^ t;
      end
   endtask

   function automatic cipher_state_type add_round_key(input cipher_state_type s, input int rnd);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            s.byte_val[c*4+r] ^= sched_words[rnd*4+c][31-8*r -: 8];
      return s;
   endfunction

   function automatic cipher_state_type substitute_shift(input cipher_state_type s,
                                                         input logic inverse);
      cipher_state_type t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            if (inverse) t.byte_val[((c+r)%4)*4+r] = inv_table[s.byte_val[c*4+r]];
            else t.byte_val[c*4+r] = fwd_table[s.byte_val[((c+r)%4)*4+r]];
         end
      return t;
   endfunction

   function automatic cipher_state_type mix_columns(input cipher_state_type s,
                                                    input logic inverse);
      cipher_state_type t;
      logic [7:0] coef [4];
      if (inverse) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            t.byte_val[c*4+r] = 8'h00;
            for (int k = 0; k < 4; k++)
               t.byte_val[c*4+r] ^= gf_product(s.byte_val[c*4+k], coef[(k-r+4)%4]);
         end
      return t;
   endfunction

   function automatic aes_pkg::aes_rsp_type cipher_block(input aes_pkg::aes_req_type item);
      cipher_state_type     s;
      aes_pkg::aes_rsp_type res;
      for (int k = 0; k < 8; k++) begin
         s.byte_val[k]   = item.block_high[63-8*k -: 8];
         s.byte_val[8+k] = item.block_low[63-8*k -: 8];
      end
      if (item.cmd == aes_pkg::CMD_ENCRYPT) begin
         s = add_round_key(s, 0);
         for (int rnd = 1; rnd < 10; rnd++) begin
            s = mix_columns(substitute_shift(s, 1'b0), 1'b0);
            s = add_round_key(s, rnd);
         end
         s = add_round_key(substitute_shift(s, 1'b0), 10);
      end else begin
         s = add_round_key(s, 10);
         for (int rnd = 9; rnd > 0; rnd--) begin
            s = add_round_key(substitute_shift(s, 1'b1), rnd);
            s = mix_columns(s, 1'b1);
         end
         s = add_round_key(substitute_shift(s, 1'b1), 0);
      end
      for (int k = 0; k < 8; k++) begin
         res.result_high[63-8*k -: 8] = s.byte_val[k];
         res.result_low[63-8*k -: 8]  = s.byte_val[8+k];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
   endtask

   task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (addr == aes_pkg::ADDR_KEY_HIGH) cur_key_high = value;
      else cur_key_low = value;
      expand_key_schedule();
   endtask

   task automatic wait_for_drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_block(input aes_pkg::aes_req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(cipher_block(item));
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_random_blocks(input int count);
      aes_pkg::aes_req_type item;
      for (int k = 0; k < count; k++) begin
         item.cmd        = 1'($urandom_range(1));
         item.block_high = random_word();
         item.block_low  = random_word();
         send_block(item);
      end
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      aes_pkg::aes_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.result_high, 64'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_high !== want.result_high)
               report_mismatch("result_high", rsp_data.result_high, want.result_high);
            if (rsp_data.result_low !== want.result_low)
               report_mismatch("result_low", rsp_data.result_low, want.result_low);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      vector_type           vectors [$];
      aes_pkg::aes_req_type item;
      aes_pkg::aes_rsp_type want;
      error_count       = 0;
      quiet_cycles      = 0;
      hold_cycles       = 0;
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      cur_key_high      = 64'h0;
      cur_key_low       = 64'h0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      build_tables();
      expand_key_schedule();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero key after reset, then the published test vectors, then extremes.
      vectors.push_back(vector_type'{aes_pkg::CMD_ENCRYPT, 64'h0, 64'h0, 1'b1,
                                     64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
      vectors.push_back(vector_type'{aes_pkg::CMD_DECRYPT, 64'h66e94bd4ef8a2c3b,
                                     64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0});
      vectors.push_back(vector_type'{aes_pkg::CMD_ENCRYPT, '1, '1, 1'b0, 64'h0, 64'h0});
      vectors.push_back(vector_type'{aes_pkg::CMD_DECRYPT, '1, '1, 1'b0, 64'h0, 64'h0});
      vectors.push_back(vector_type'{aes_pkg::CMD_DECRYPT, 64'h0, 64'h0, 1'b0,
                                     64'h0, 64'h0});
      vectors.push_back(vector_type'{aes_pkg::CMD_ENCRYPT, 64'h8000000000000000, 64'h1,
                                     1'b0, 64'h0, 64'h0});
      foreach (vectors[k]) begin
         item = aes_pkg::aes_req_type'{vectors[k].cmd, vectors[k].block_high,
                                       vectors[k].block_low};
         want = cipher_block(item);
         if (vectors[k].known && (want.result_high !== vectors[k].want_high ||
                                  want.result_low !== vectors[k].want_low))
            report_mismatch("predictor", want.result_high, vectors[k].want_high);
         send_block(item);
      end
      req_valid <= 1'b0;
      wait_for_drain();

      write_key(aes_pkg::ADDR_KEY_HIGH, 64'h0001020304050607);
      write_key(aes_pkg::ADDR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      send_block(aes_pkg::aes_req_type'{aes_pkg::CMD_ENCRYPT, 64'h0011223344556677,
                                        64'h8899aabbccddeeff});
      send_block(aes_pkg::aes_req_type'{aes_pkg::CMD_DECRYPT, 64'h69c4e0d86a7b0430,
                                        64'hd8cdb78070b4c55a});
      req_valid <= 1'b0;
      wait_for_drain();
      want = cipher_block(aes_pkg::aes_req_type'{aes_pkg::CMD_ENCRYPT, 64'h0011223344556677,
                                                 64'h8899aabbccddeeff});
      if (want.result_high !== 64'h69c4e0d86a7b0430)
         report_mismatch("predictor", want.result_high, 64'h69c4e0d86a7b0430);

      write_key(aes_pkg::ADDR_KEY_HIGH, '1);
      write_key(aes_pkg::ADDR_KEY_LOW, '1);
      send_random_blocks(8);
      wait_for_drain();

      sender_idle_pct   = 10;
      receiver_idle_pct = 78;
      write_key(aes_pkg::ADDR_KEY_HIGH, random_word());
      write_key(aes_pkg::ADDR_KEY_LOW, random_word());
      send_random_blocks(500);
      wait_for_drain();

      sender_idle_pct   = 78;
      receiver_idle_pct = 10;
      write_key(aes_pkg::ADDR_KEY_LOW, random_word());
      send_random_blocks(500);
      wait_for_drain();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_key(aes_pkg::ADDR_KEY_HIGH, random_word());
      write_key(aes_pkg::ADDR_KEY_LOW, random_word());
      hold_cycles = 300;
      send_random_blocks(300);
      wait_for_drain();
      write_key(aes_pkg::ADDR_KEY_HIGH, 64'h0);
      write_key(aes_pkg::ADDR_KEY_LOW, 64'h0);
      send_random_blocks(290);
      wait_for_drain();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
